// ===== rtl/core/degree_capped_kruskal_edge_acceptor_defines.svh =====
// assertion helpers used by the acceptor rtl file
// each macro expects clk and arst_n in scope
`ifndef DEGREE_CAPPED_KRUSKAL_EDGE_ACCEPTOR_DEFINES_SVH
`define DEGREE_CAPPED_KRUSKAL_EDGE_ACCEPTOR_DEFINES_SVH

// same-cycle implication
`define DCKA_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DCKA_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/dcka_pkg.sv =====
`default_nettype none

package dcka_pkg;

	// fixed field widths
	localparam int NODE_W      = 6;
	localparam int NODE_SPAN   = 2 ** NODE_W;
	localparam int DEG_W       = 6;
	localparam int COUNT_W     = 6;
	localparam int NCOUNT_W    = 7;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [NCOUNT_W-1:0] NCOUNT_RESET = 7'd64;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_EDGE = 1'b1;

	typedef enum logic [2:0] {
		OUT_ACCEPTED   = 3'd0,
		OUT_AT_CAP     = 3'd1,
		OUT_SAME_COMP  = 3'd2,
		OUT_COMPLETE   = 3'd3,
		OUT_CAP_LOADED = 3'd4
	} outcome_t;

	// input payload, node_a in the lowest bits
	typedef struct packed {
		logic [DEG_W-1:0]  cap_value;
		logic [NODE_W-1:0] node_b;
		logic [NODE_W-1:0] node_a;
	} in_data_t;

	// result payload, outcome in the lowest bits
	typedef struct packed {
		logic               tree_complete;
		logic [COUNT_W-1:0] edges_added;
		outcome_t           outcome;
	} result_t;

	// per-node degree record
	typedef struct packed {
		logic [DEG_W-1:0] cap;
		logic [DEG_W-1:0] degree;
	} deg_word_t;

endpackage

`default_nettype wire

// ===== rtl/core/degree_capped_kruskal_edge_acceptor.sv =====
// Greedy spanning-tree edge acceptor with per-node degree caps. Each input
// transaction is either a cap load (tuser 0: store cap_value as the degree cap
// of node_a) or an edge offer (tuser 1: node_a to node_b, offered in weight
// order). An edge is taken only if the tree is not yet complete, both endpoints
// are below their caps and the endpoints sit in different union-find sets;
// find uses path halving, union is by size with the node_a root winning ties.
// Every input transaction yields exactly one output transaction with the
// outcome, the accepted edge count and the completion flag. Node indices wrap
// modulo MAX_NODES; node_count is clamped to 2..MAX_NODES. Per-node state sits
// in two single-read-port memories (parent/size and cap/degree). After reset
// an init sweep fills them while s_tready stays low;
// node_count writes are taken at any time. An edge offer while the tree is
// complete goes straight to the result; otherwise both degree records are
// read, the caps checked, both finds run and, for distinct sets, the union
// written. Each path-halving step makes two reads of the parent memory, one
// per parent hop. The next input is taken while a result still waits in the
// output register; a result is only held back if that register is still
// occupied when the next one finishes.
`default_nettype none

`include "degree_capped_kruskal_edge_acceptor_defines.svh"

module degree_capped_kruskal_edge_acceptor #(
	parameter int MAX_NODES = 64
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	// node_count register
	input  wire                                    cfg_we,
	input  wire  [dcka_pkg::NCOUNT_W-1:0]          cfg_wdata,
	// input items
	input  wire                                    s_tvalid,
	output logic                                   s_tready,
	input  wire  [dcka_pkg::IN_TDATA_W-1:0]        s_tdata,  // node_a[5:0], node_b[11:6], cap_value[17:12]
	input  wire                                    s_tuser,  // mode
	// results
	output logic                                   m_tvalid,
	input  wire                                    m_tready,
	output logic [dcka_pkg::OUT_TDATA_W-1:0]       m_tdata   // outcome[2:0], edges_added[8:3], tree_complete[9]
);

	localparam int IDX_W    = $clog2(MAX_NODES);
	localparam int SZ_W     = $clog2(MAX_NODES + 1);
	localparam int LINK_W   = SZ_W + IDX_W;
	localparam int CMP_W    = (SZ_W > dcka_pkg::NCOUNT_W) ? SZ_W : dcka_pkg::NCOUNT_W;

	// one-hot sequencer
	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_DEG_A   = 9'b000000010,
		S_DEG_B   = 9'b000000100,
		S_CAP_CHK = 9'b000001000,
		S_FIND_P  = 9'b000010000,
		S_FIND_GP = 9'b000100000,
		S_JOIN1   = 9'b001000000,
		S_JOIN2   = 9'b010000000,
		S_FINISH  = 9'b100000000
	} state_t;

	state_t                         state_q;
	state_t                         state_d;

	// register and counters
	logic [dcka_pkg::NCOUNT_W-1:0]  node_count_q;
	logic [dcka_pkg::COUNT_W-1:0]   count_q;
	logic                           find_b_q;
	logic                           out_valid_q;

	// item context
	logic                           mode_q;
	logic [IDX_W-1:0]               a_q;
	logic [IDX_W-1:0]               b_q;
	logic [dcka_pkg::DEG_W-1:0]     cap_q;
	dcka_pkg::deg_word_t            deg_a_q;
	dcka_pkg::deg_word_t            deg_b_q;
	dcka_pkg::outcome_t             outcome_q;
	dcka_pkg::result_t              out_data_q;

	// find walk
	logic [IDX_W-1:0]               x_q;
	logic [SZ_W-1:0]                xsz_q;
	logic [IDX_W-1:0]               ra_q;
	logic [IDX_W-1:0]               rb_q;
	logic [SZ_W-1:0]                sa_q;
	logic [SZ_W-1:0]                sb_q;

	// memory ports
	logic                           link_we;
	logic [IDX_W-1:0]               link_waddr;
	logic [LINK_W-1:0]              link_wdata;
	logic [IDX_W-1:0]               link_raddr;
	logic [LINK_W-1:0]              link_rdata;
	logic                           deg_we;
	logic [IDX_W-1:0]               deg_waddr;
	dcka_pkg::deg_word_t            deg_wdata;
	logic [IDX_W-1:0]               deg_raddr;
	dcka_pkg::deg_word_t            deg_rdata;
	logic                           clr_busy;

	dcka_pkg::in_data_t             in_d;
	logic                           in_acc;
	logic                           out_load;
	logic [IDX_W-1:0]               rd_parent;
	logic [SZ_W-1:0]                rd_size;
	logic                           at_root;
	logic                           b_wins;
	logic [IDX_W-1:0]               big_root;
	logic [IDX_W-1:0]               small_root;
	logic [SZ_W-1:0]                small_size;
	logic [CMP_W-1:0]               nc_ext;
	logic [CMP_W-1:0]               eff_nodes;
	logic                           complete;

	// index wrap table, node field value modulo MAX_NODES
	logic [IDX_W-1:0]               idx_map [dcka_pkg::NODE_SPAN];

	for (genvar g = 0; g < dcka_pkg::NODE_SPAN; g++) begin : g_idx_map
		assign idx_map[g] = IDX_W'(g % MAX_NODES);
	end

	dcka_node_store #(
		.MAX_NODES (MAX_NODES)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.link_we    (link_we),
		.link_waddr (link_waddr),
		.link_wdata (link_wdata),
		.link_raddr (link_raddr),
		.link_rdata (link_rdata),
		.deg_we     (deg_we),
		.deg_waddr  (deg_waddr),
		.deg_wdata  (deg_wdata),
		.deg_raddr  (deg_raddr),
		.deg_rdata  (deg_rdata),
		.clr_busy   (clr_busy)
	);

	assign in_d     = dcka_pkg::in_data_t'(s_tdata[$bits(dcka_pkg::in_data_t)-1:0]);
	assign s_tready = (state_q == S_IDLE) && !clr_busy;
	assign in_acc   = s_tvalid && s_tready;
	assign out_load = (state_q == S_FINISH) && (!out_valid_q || m_tready);

	// link word read back for the node under x_q
	assign rd_parent = link_rdata[IDX_W-1:0];
	assign rd_size   = link_rdata[LINK_W-1:IDX_W];
	assign at_root   = (rd_parent == x_q);

	// union by size, node_a root keeps ties
	assign b_wins     = (sa_q < sb_q);
	assign big_root   = b_wins ? rb_q : ra_q;
	assign small_root = b_wins ? ra_q : rb_q;
	assign small_size = b_wins ? sa_q : sb_q;

	// tree complete once count reaches clamped node count minus one
	always_comb begin
		nc_ext = CMP_W'(node_count_q);
		if (nc_ext < CMP_W'(2)) begin
			eff_nodes = CMP_W'(2);
		end else if (nc_ext > CMP_W'(MAX_NODES)) begin
			eff_nodes = CMP_W'(MAX_NODES);
		end else begin
			eff_nodes = nc_ext;
		end
		complete = (CMP_W'(count_q) >= (eff_nodes - CMP_W'(1)));
	end

	// sequencer and memory port control
	always_comb begin
		state_d    = state_q;
		link_we    = 1'b0;
		link_waddr = x_q;
		link_wdata = {xsz_q, rd_parent};
		link_raddr = x_q;
		deg_we     = 1'b0;
		deg_waddr  = a_q;
		deg_wdata  = deg_a_q;
		deg_raddr  = a_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_d = (s_tuser == dcka_pkg::MODE_EDGE && complete) ? S_FINISH : S_DEG_A;
				end
			end
			S_DEG_A: begin
				deg_raddr = a_q;
				state_d   = S_DEG_B;
			end
			S_DEG_B: begin
				deg_raddr = b_q;
				if (mode_q == dcka_pkg::MODE_LOAD) begin
					// keep the degree, replace the cap
					deg_we    = 1'b1;
					deg_waddr = a_q;
					deg_wdata = '{cap: cap_q, degree: deg_rdata.degree};
					state_d   = S_FINISH;
				end else begin
					state_d = S_CAP_CHK;
				end
			end
			S_CAP_CHK: begin
				if ((deg_a_q.degree >= deg_a_q.cap) || (deg_rdata.degree >= deg_rdata.cap)) begin
					state_d = S_FINISH;
				end else begin
					link_raddr = a_q;
					state_d    = S_FIND_P;
				end
			end
			S_FIND_P: begin
				if (at_root) begin
					if (!find_b_q) begin
						link_raddr = b_q;
					end else begin
						state_d = (x_q == ra_q) ? S_FINISH : S_JOIN1;
					end
				end else begin
					link_raddr = rd_parent;
					state_d    = S_FIND_GP;
				end
			end
			S_FIND_GP: begin
				// halve: x points at its grandparent, walk on from there
				link_we    = 1'b1;
				link_waddr = x_q;
				link_wdata = {xsz_q, rd_parent};
				link_raddr = rd_parent;
				state_d    = S_FIND_P;
			end
			S_JOIN1: begin
				link_we    = 1'b1;
				link_waddr = small_root;
				link_wdata = {small_size, big_root};
				deg_we     = 1'b1;
				deg_waddr  = a_q;
				deg_wdata  = '{cap: deg_a_q.cap, degree: deg_a_q.degree + 1'b1};
				state_d    = S_JOIN2;
			end
			S_JOIN2: begin
				link_we    = 1'b1;
				link_waddr = big_root;
				link_wdata = {SZ_W'(sa_q + sb_q), big_root};
				deg_we     = 1'b1;
				deg_waddr  = b_q;
				deg_wdata  = '{cap: deg_b_q.cap, degree: deg_b_q.degree + 1'b1};
				state_d    = S_FINISH;
			end
			S_FINISH: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			node_count_q <= dcka_pkg::NCOUNT_RESET;
			count_q      <= '0;
			find_b_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end
			// saturating edge count
			if (state_q == S_JOIN2 && count_q != dcka_pkg::COUNT_MAX) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == S_CAP_CHK) begin
				find_b_q <= 1'b0;
			end else if (state_q == S_FIND_P && at_root) begin
				find_b_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item context and walk registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q    <= s_tuser;
			a_q       <= idx_map[in_d.node_a];
			b_q       <= idx_map[in_d.node_b];
			cap_q     <= in_d.cap_value;
			outcome_q <= (s_tuser == dcka_pkg::MODE_EDGE) ? dcka_pkg::OUT_COMPLETE
			                                              : dcka_pkg::OUT_CAP_LOADED;
		end
		case (state_q)
			S_DEG_B: begin
				deg_a_q <= deg_rdata;
			end
			S_CAP_CHK: begin
				deg_b_q   <= deg_rdata;
				x_q       <= a_q;
				outcome_q <= dcka_pkg::OUT_AT_CAP;
			end
			S_FIND_P: begin
				xsz_q <= rd_size;
				if (at_root) begin
					if (!find_b_q) begin
						ra_q <= x_q;
						sa_q <= rd_size;
						x_q  <= b_q;
					end else begin
						rb_q      <= x_q;
						sb_q      <= rd_size;
						outcome_q <= dcka_pkg::OUT_SAME_COMP;
					end
				end
			end
			S_FIND_GP: begin
				x_q <= rd_parent;
			end
			S_JOIN2: begin
				outcome_q <= dcka_pkg::OUT_ACCEPTED;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_data_q <= '{tree_complete: complete, edges_added: count_q, outcome: outcome_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = dcka_pkg::OUT_TDATA_W'(out_data_q);

	// edge count moves only on a union
	`DCKA_ASSERT_NEXT(a_count_only_on_join, state_q != S_JOIN2, $stable(count_q), "edge count changed outside a union")
	// union never merges a set with itself
	`DCKA_ASSERT_IMPL(a_join_distinct_roots, state_q == S_JOIN1, ra_q != rb_q, "union of equal roots")
	// both endpoints were below their caps
	`DCKA_ASSERT_IMPL(a_join_under_cap, state_q == S_JOIN1, (deg_a_q.degree < deg_a_q.cap) && (deg_b_q.degree < deg_b_q.cap), "union with an endpoint at its cap")
	// an accepted transaction always starts work
	`DCKA_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_q != S_IDLE, "input accepted but sequencer stayed idle")

endmodule

`default_nettype wire

// ===== rtl/core/dcka_node_store.sv =====
`default_nettype none

module dcka_node_store #(
	parameter int MAX_NODES = 64
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    link_we,
	input  wire  [$clog2(MAX_NODES)-1:0]           link_waddr,
	input  wire  [$clog2(MAX_NODES+1)+$clog2(MAX_NODES)-1:0] link_wdata,
	input  wire  [$clog2(MAX_NODES)-1:0]           link_raddr,
	output logic [$clog2(MAX_NODES+1)+$clog2(MAX_NODES)-1:0] link_rdata,
	input  wire                                    deg_we,
	input  wire  [$clog2(MAX_NODES)-1:0]           deg_waddr,
	input  dcka_pkg::deg_word_t                    deg_wdata,
	input  wire  [$clog2(MAX_NODES)-1:0]           deg_raddr,
	output dcka_pkg::deg_word_t                    deg_rdata,
	output logic                                   clr_busy
);

	localparam int IDX_W  = $clog2(MAX_NODES);
	localparam int SZ_W   = $clog2(MAX_NODES + 1);
	localparam int LINK_W = SZ_W + IDX_W;

	// link word is {size, parent}
	logic [LINK_W-1:0]    link_mem [MAX_NODES];
	dcka_pkg::deg_word_t  deg_mem  [MAX_NODES];

	logic                 clr_busy_q;
	logic [IDX_W-1:0]     clr_idx_q;

	logic                 l_we;
	logic [IDX_W-1:0]     l_waddr;
	logic [LINK_W-1:0]    l_wdata;
	logic                 d_we;
	logic [IDX_W-1:0]     d_waddr;
	dcka_pkg::deg_word_t  d_wdata;

	// init sweep: parent = self, size = 1, degree and cap = 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_idx_q == IDX_W'(MAX_NODES - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	always_comb begin
		l_we    = clr_busy_q | link_we;
		l_waddr = clr_busy_q ? clr_idx_q : link_waddr;
		l_wdata = clr_busy_q ? {SZ_W'(1), clr_idx_q} : link_wdata;
		d_we    = clr_busy_q | deg_we;
		d_waddr = clr_busy_q ? clr_idx_q : deg_waddr;
		d_wdata = clr_busy_q ? '0 : deg_wdata;
	end

	// write-first bypass on same-address read
	always_ff @(posedge clk) begin
		if (l_we) begin
			link_mem[l_waddr] <= l_wdata;
		end
		if (l_we && (l_waddr == link_raddr)) begin
			link_rdata <= l_wdata;
		end else begin
			link_rdata <= link_mem[link_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (d_we) begin
			deg_mem[d_waddr] <= d_wdata;
		end
		if (d_we && (d_waddr == deg_raddr)) begin
			deg_rdata <= d_wdata;
		end else begin
			deg_rdata <= deg_mem[deg_raddr];
		end
	end

	assign clr_busy = clr_busy_q;

endmodule

`default_nettype wire
